/* rtl/zbbalu_pkg.sv */
// Package for the RV32 Zbb bit-manipulation ALU: operation codes and field widths.
// No dependencies; the top level refers to it by scoped names.
package zbbalu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CmdW  = 5;
  localparam int unsigned CntW  = 6;   // holds 0 to 32
  localparam int unsigned ByteCntW = 4; // holds 0 to 8
  localparam int unsigned RotW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_ANDN  = 5'd0,
    CMD_ORN   = 5'd1,
    CMD_XNOR  = 5'd2,
    CMD_CLZ   = 5'd3,
    CMD_CTZ   = 5'd4,
    CMD_CPOP  = 5'd5,
    CMD_MAX   = 5'd6,
    CMD_MAXU  = 5'd7,
    CMD_MIN   = 5'd8,
    CMD_MINU  = 5'd9,
    CMD_SEXTB = 5'd10,
    CMD_SEXTH = 5'd11,
    CMD_ZEXTH = 5'd12,
    CMD_ROL   = 5'd13,
    CMD_ROR   = 5'd14,
    CMD_ORCB  = 5'd15,
    CMD_REV8  = 5'd16
  } cmd_e;

  typedef logic [ByteCntW-1:0] byte_cnt_t;

endpackage

/* rtl/rv32_zbb_bitmanip_alu_top.sv */
// Top level of the RV32 Zbb bit-manipulation ALU, a three-stage pipeline.
// Depends on zbbalu_pkg for the operation codes and widths.
//
//   Channel   Direction  Handshake                     Payload
//   s_axis    in         s_axis_tvalid_i/tready_o      tuser: cmd; tdata: src_a, src_b
//   m_axis    out        m_axis_tvalid_o/tready_i      tdata: result
//
// Stage one does the logic operations, the compares for max and min, the
// fine part of the rotate and the per-byte counts; stage two finishes the
// rotate and merges the byte counts; stage three is the output register
// that picks the result.
// One transfer may be accepted in every cycle, so the sustained rate is one
// item per clock. Each stage carries its own valid bit, and a stage loads
// whenever it is empty or the stage after it moves on, so a stall at the
// output fills bubbles before it holds back the input, and nothing is lost
// or repeated. Reset (asynchronous, active low) clears only the valid bits.
module rv32_zbb_bitmanip_alu_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [4:0]  s_axis_tuser_i,   // [4:0] cmd
  input  logic [63:0] s_axis_tdata_i,   // [31:0] src_a, [63:32] src_b
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] result
);

  localparam int unsigned W = zbbalu_pkg::WordW;

  // Leading zeros of one byte, 8 when the byte is zero.
  function automatic zbbalu_pkg::byte_cnt_t byte_lz(input logic [7:0] v);
    zbbalu_pkg::byte_cnt_t n;
    logic                  hit;
    n   = '0;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit) begin
        if (v[i]) hit = 1'b1;
        else n = n + 4'd1;
      end
    end
    return n;
  endfunction

  // Trailing zeros of one byte, 8 when the byte is zero.
  function automatic zbbalu_pkg::byte_cnt_t byte_tz(input logic [7:0] v);
    zbbalu_pkg::byte_cnt_t n;
    logic                  hit;
    n   = '0;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!hit) begin
        if (v[i]) hit = 1'b1;
        else n = n + 4'd1;
      end
    end
    return n;
  endfunction

  // Number of set bits in one byte.
  function automatic zbbalu_pkg::byte_cnt_t byte_pop(input logic [7:0] v);
    zbbalu_pkg::byte_cnt_t n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

  // Handshake chain: a stage may load when it is empty or drains this cycle.
  logic rdy1, rdy2, rdy3;
  logic v1_q, v2_q, v3_q;

  assign rdy3            = !v3_q || m_axis_tready_i;
  assign rdy2            = !v2_q || rdy3;
  assign rdy1            = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;
  assign m_axis_tvalid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage one.
  // ---------------------------------------------------------------------
  zbbalu_pkg::cmd_e cmd0;
  logic [W-1:0]     a0, b0;
  logic [W-1:0]     simple1_d;
  logic             lt_s, lt_u;
  logic [zbbalu_pkg::RotW-1:0] amt0;
  logic [2*W-1:0]   dbl0;
  logic [W-1:0]     rot1_d;

  assign cmd0 = zbbalu_pkg::cmd_e'(s_axis_tuser_i);
  assign a0   = s_axis_tdata_i[31:0];
  assign b0   = s_axis_tdata_i[63:32];
  assign lt_s = $signed(a0) < $signed(b0);
  assign lt_u = a0 < b0;

  // A left rotate is a right rotate by the negated amount; zero stays zero.
  assign amt0   = (cmd0 == zbbalu_pkg::CMD_ROL) ? (5'd0 - b0[4:0]) : b0[4:0];
  assign dbl0   = {a0, a0} >> amt0[2:0];
  assign rot1_d = dbl0[W-1:0];

  always_comb begin
    simple1_d = '0;
    unique case (cmd0)
      zbbalu_pkg::CMD_ANDN:  simple1_d = a0 & ~b0;
      zbbalu_pkg::CMD_ORN:   simple1_d = a0 | ~b0;
      zbbalu_pkg::CMD_XNOR:  simple1_d = ~(a0 ^ b0);
      zbbalu_pkg::CMD_MAX:   simple1_d = lt_s ? b0 : a0;
      zbbalu_pkg::CMD_MAXU:  simple1_d = lt_u ? b0 : a0;
      zbbalu_pkg::CMD_MIN:   simple1_d = lt_s ? a0 : b0;
      zbbalu_pkg::CMD_MINU:  simple1_d = lt_u ? a0 : b0;
      zbbalu_pkg::CMD_SEXTB: simple1_d = {{24{a0[7]}}, a0[7:0]};
      zbbalu_pkg::CMD_SEXTH: simple1_d = {{16{a0[15]}}, a0[15:0]};
      zbbalu_pkg::CMD_ZEXTH: simple1_d = {16'h0000, a0[15:0]};
      zbbalu_pkg::CMD_ORCB:  simple1_d = {{8{|a0[31:24]}}, {8{|a0[23:16]}},
                                          {8{|a0[15:8]}}, {8{|a0[7:0]}}};
      zbbalu_pkg::CMD_REV8:  simple1_d = {a0[7:0], a0[15:8], a0[23:16], a0[31:24]};
      default:               simple1_d = '0;
    endcase
  end

  zbbalu_pkg::cmd_e      cmd1_q;
  logic [W-1:0]          simple1_q;
  logic [W-1:0]          rot1_q;
  logic [1:0]            amt_hi1_q;
  zbbalu_pkg::byte_cnt_t lz1_q [4];
  zbbalu_pkg::byte_cnt_t tz1_q [4];
  zbbalu_pkg::byte_cnt_t pc1_q [4];

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      cmd1_q    <= cmd0;
      simple1_q <= simple1_d;
      rot1_q    <= rot1_d;
      amt_hi1_q <= amt0[4:3];
      for (int k = 0; k < 4; k++) begin
        lz1_q[k] <= byte_lz(a0[8*k +: 8]);
        tz1_q[k] <= byte_tz(a0[8*k +: 8]);
        pc1_q[k] <= byte_pop(a0[8*k +: 8]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage two: coarse rotate by whole bytes and merging of byte counts.
  // ---------------------------------------------------------------------
  logic [2*W-1:0]                dbl1;
  logic [zbbalu_pkg::CntW-1:0]   clz1, ctz1, pop1, cnt2_d;

  assign dbl1 = {rot1_q, rot1_q} >> {amt_hi1_q, 3'b000};

  // A zero byte counts 8, so a zero word falls through to 32.
  always_comb begin
    priority if (lz1_q[3] != 4'd8) clz1 = {2'b00, lz1_q[3]};
    else if (lz1_q[2] != 4'd8)     clz1 = 6'd8 + {2'b00, lz1_q[2]};
    else if (lz1_q[1] != 4'd8)     clz1 = 6'd16 + {2'b00, lz1_q[1]};
    else                           clz1 = 6'd24 + {2'b00, lz1_q[0]};
  end

  always_comb begin
    priority if (tz1_q[0] != 4'd8) ctz1 = {2'b00, tz1_q[0]};
    else if (tz1_q[1] != 4'd8)     ctz1 = 6'd8 + {2'b00, tz1_q[1]};
    else if (tz1_q[2] != 4'd8)     ctz1 = 6'd16 + {2'b00, tz1_q[2]};
    else                           ctz1 = 6'd24 + {2'b00, tz1_q[3]};
  end

  assign pop1 = ({2'b00, pc1_q[0]} + {2'b00, pc1_q[1]}) +
                ({2'b00, pc1_q[2]} + {2'b00, pc1_q[3]});

  always_comb begin
    cnt2_d = '0;
    unique case (cmd1_q)
      zbbalu_pkg::CMD_CLZ:  cnt2_d = clz1;
      zbbalu_pkg::CMD_CTZ:  cnt2_d = ctz1;
      zbbalu_pkg::CMD_CPOP: cnt2_d = pop1;
      default:              cnt2_d = '0;
    endcase
  end

  zbbalu_pkg::cmd_e            cmd2_q;
  logic [W-1:0]                simple2_q;
  logic [W-1:0]                rot2_q;
  logic [zbbalu_pkg::CntW-1:0] cnt2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      cmd2_q    <= cmd1_q;
      simple2_q <= simple1_q;
      rot2_q    <= dbl1[W-1:0];
      cnt2_q    <= cnt2_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage three: result selection into the output register.
  // ---------------------------------------------------------------------
  logic [W-1:0] res3_d;
  logic [W-1:0] res3_q;

  always_comb begin
    res3_d = simple2_q;
    unique case (cmd2_q)
      zbbalu_pkg::CMD_ROL,
      zbbalu_pkg::CMD_ROR:  res3_d = rot2_q;
      zbbalu_pkg::CMD_CLZ,
      zbbalu_pkg::CMD_CTZ,
      zbbalu_pkg::CMD_CPOP: res3_d = {{(W-zbbalu_pkg::CntW){1'b0}}, cnt2_q};
      default:              res3_d = simple2_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      res3_q <= res3_d;
    end
  end

  assign m_axis_tdata_o = res3_q;

endmodule
